>>> hdl/frame_bitmap_allocator_assert.svh
// Assertion macros for the allocator RTL (included by the controller).
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed (same cycle)");

// next-cycle implication
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed (next cycle)");

`endif

>>> hdl/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package fba_pkg;

    localparam int FRAME_W     = 20;
    localparam int FC_W        = 13;
    localparam int WORD_BITS   = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [FC_W-1:0] FC_RESET = 13'd4096;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        RES_ALLOC,
        RES_FREE,
        RES_NOTHING,
        RES_FULL
    } res_kind_t;

    typedef struct packed {
        logic      clr_step;
        logic      load;
        logic      scan_step;
        logic      alloc_wr;
        logic      free_rd;
        logic      free_wr;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic act_free;
        logic base_zero;
        logic free_in_range;
        logic hit;
        logic exhausted;
    } sts_t;

endpackage

>>> hdl/fba_datapath.sv
// Datapath: bitmap memory, scan counters, item and result registers.
// Depends on fba_pkg; driven by fba_ctrl through cmd_t / sts_t.
`timescale 1ns / 1ps

module fba_datapath #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [fba_pkg::FC_W-1:0]           cfg_wdata,
    input  logic [fba_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    input  fba_pkg::cmd_t                      cmd,
    output fba_pkg::sts_t                      sts,
    output logic [fba_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int WORDS = (MAX_FRAMES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(WORDS + 1);
    localparam logic [20:0] MAX_LIM   = 21'(MAX_FRAMES);
    localparam logic [20:0] WORDS_LIM = 21'(WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    logic [fba_pkg::WORD_BITS-1:0] mem [WORDS];

    logic [fba_pkg::FC_W-1:0]      frame_count_reg;
    logic [AW-1:0]                 clr_reg;
    logic [CW-1:0]                 issue_reg;
    logic [CW-1:0]                 lim_reg;
    logic                          pend_reg;
    logic [AW-1:0]                 chk_reg;
    logic [fba_pkg::WORD_BITS-1:0] rd_data_reg;

    logic                          act_reg;
    logic [fba_pkg::FRAME_W-1:0]   base_reg;
    logic                          kern_reg;
    logic                          wrbl_reg;
    logic [fba_pkg::FRAME_W-1:0]   frame_reg;

    logic [fba_pkg::FRAME_W-1:0]   entry_base_reg;
    logic                          present_reg;
    logic                          write_bit_reg;
    logic                          user_bit_reg;
    logic [1:0]                    status_reg;

    logic [20:0]                   fc_ext;
    logic [20:0]                   lim;
    logic [CW-1:0]                 lim_words;
    logic [14:0]                   free_idx;
    logic                          scan_issue;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [fba_pkg::WORD_BITS-1:0] wr_data;
    logic [4:0]                    zero_bit;

    // usable word count: min(frame_count, MAX_FRAMES) / 32
    assign fc_ext    = {8'b0, frame_count_reg};
    assign lim       = (fc_ext > MAX_LIM) ? MAX_LIM : fc_ext;
    assign lim_words = CW'(lim >> 5);

    assign free_idx   = base_reg[19:5];
    assign scan_issue = cmd.scan_step && (issue_reg < lim_reg);

    // lowest clear bit of the word under test
    always_comb
    begin
        zero_bit = '0;
        for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rd_data_reg[i])
            begin
                zero_bit = 5'(i);
            end
        end
    end

    assign rd_en   = scan_issue || cmd.free_rd;
    assign rd_addr = cmd.free_rd ? free_idx[AW-1:0] : issue_reg[AW-1:0];
    assign wr_en   = cmd.clr_step || cmd.alloc_wr || cmd.free_wr;

    always_comb
    begin
        priority if (cmd.clr_step)
        begin
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (cmd.alloc_wr)
        begin
            wr_addr = chk_reg;
            wr_data = rd_data_reg | (32'd1 << zero_bit);
        end
        else
        begin
            wr_addr = free_idx[AW-1:0];
            wr_data = rd_data_reg & ~(32'd1 << base_reg[4:0]);
        end
    end

    assign sts.clr_last      = (clr_reg == LAST_WORD);
    assign sts.act_free      = (act_reg == fba_pkg::ACT_FREE);
    assign sts.base_zero     = (base_reg == '0);
    assign sts.free_in_range = ({6'b0, free_idx} < WORDS_LIM);
    assign sts.hit           = pend_reg && (rd_data_reg != '1);
    assign sts.exhausted     = !pend_reg && (issue_reg >= lim_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= fba_pkg::FC_RESET;
            clr_reg         <= '0;
            issue_reg       <= '0;
            lim_reg         <= '0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                frame_count_reg <= cfg_wdata;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                issue_reg <= '0;
                lim_reg   <= lim_words;
                pend_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
            end
        end
    end

    // memory and payload registers
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (scan_issue)
        begin
            chk_reg <= issue_reg[AW-1:0];
        end
        if (cmd.load)
        begin
            act_reg  <= s_tuser;
            base_reg <= s_tdata[19:0];
            kern_reg <= s_tdata[20];
            wrbl_reg <= s_tdata[21];
        end
        if (cmd.alloc_wr)
        begin
            frame_reg <= fba_pkg::FRAME_W'({chk_reg, zero_bit});
        end
        if (cmd.res_load)
        begin
            unique case (cmd.res_kind)
                fba_pkg::RES_ALLOC:
                begin
                    entry_base_reg <= frame_reg;
                    present_reg    <= 1'b1;
                    write_bit_reg  <= wrbl_reg;
                    user_bit_reg   <= !kern_reg;
                    status_reg     <= fba_pkg::ST_DONE;
                end
                fba_pkg::RES_FREE:
                begin
                    entry_base_reg <= '0;
                    present_reg    <= 1'b0;
                    write_bit_reg  <= 1'b0;
                    user_bit_reg   <= 1'b0;
                    status_reg     <= fba_pkg::ST_DONE;
                end
                fba_pkg::RES_NOTHING:
                begin
                    entry_base_reg <= base_reg;
                    present_reg    <= 1'b0;
                    write_bit_reg  <= 1'b0;
                    user_bit_reg   <= 1'b0;
                    status_reg     <= fba_pkg::ST_IDLE;
                end
                default:
                begin
                    entry_base_reg <= base_reg;
                    present_reg    <= 1'b0;
                    write_bit_reg  <= 1'b0;
                    user_bit_reg   <= 1'b0;
                    status_reg     <= fba_pkg::ST_FULL;
                end
            endcase
        end
    end

    assign m_tdata = {7'b0, status_reg, user_bit_reg, write_bit_reg, present_reg,
                      entry_base_reg};

endmodule

>>> hdl/fba_ctrl.sv
// Controller state machine: clearing pass, request dispatch, scan, free, result hand-off.
// Depends on fba_pkg and frame_bitmap_allocator_assert.svh.
`timescale 1ns / 1ps
`include "frame_bitmap_allocator_assert.svh"

module fba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  fba_pkg::sts_t sts,
    output fba_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic                ready_reg, ready_next;
    logic                out_valid_reg, out_valid_next;
    fba_pkg::res_kind_t  kind_reg, kind_next;

    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && !m_tready;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.res_kind   = kind_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.act_free)
                begin
                    if (sts.base_zero)
                    begin
                        kind_next  = fba_pkg::RES_NOTHING;
                        state_next = S_FINISH;
                    end
                    else if (sts.free_in_range)
                    begin
                        state_next = S_FREE_RD;
                    end
                    else
                    begin
                        kind_next  = fba_pkg::RES_FREE;
                        state_next = S_FINISH;
                    end
                end
                else if (!sts.base_zero)
                begin
                    kind_next  = fba_pkg::RES_NOTHING;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.alloc_wr = 1'b1;
                    kind_next    = fba_pkg::RES_ALLOC;
                    state_next   = S_FINISH;
                end
                else if (sts.exhausted)
                begin
                    kind_next  = fba_pkg::RES_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
                state_next  = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                kind_next   = fba_pkg::RES_FREE;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    ready_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= fba_pkg::RES_NOTHING;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
        end
    end

    assign s_tready = ready_reg;
    assign m_tvalid = out_valid_reg;

    `FBA_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, s_tvalid && ready_reg, state_reg == S_DISPATCH)
    `FBA_ASSERT_IMPL(a_one_write, clk, rst_n, 1'b1, $onehot0({cmd.clr_step, cmd.alloc_wr, cmd.free_wr}))
    `FBA_ASSERT_NEXT(a_hit_finish, clk, rst_n, state_reg == S_SCAN && sts.hit, state_reg == S_FINISH)
    `FBA_ASSERT_IMPL(a_clear_blocks, clk, rst_n, state_reg == S_CLEAR, !ready_reg)

endmodule

>>> hdl/frame_bitmap_allocator.sv
// Allocate: dispatch, scan (up to min(frame_count,MAX_FRAMES)/32 words), finish. Free: dispatch,
//   read, write, finish; trivial: dispatch, finish. One item in flight (scan: one word/cycle).
// The bitmap memory read (registered) sets the scan pace of one 32-frame word per cycle.
// Reset (rst_n low, async): control cleared, frame_count = 4096; then a clearing pass
//   zeroes every bitmap word with s_tready low; config writes still taken.
`timescale 1ns / 1ps

// Top level: first-fit bitmap frame allocator.
// Instantiates fba_ctrl and fba_datapath; depends on fba_pkg.
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = 4096   // frames the bitmap can track, 32 .. 1048576
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // frame_count register: written whenever cfg_wen is high
    input  logic                            cfg_wen,
    input  logic [fba_pkg::FC_W-1:0]        cfg_wdata,

    // request item
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fba_pkg::IN_TDATA_W-1:0]  s_tdata,   // page_base[19:0], kernel_page[20],
                                                       // writable[21], zero pad
    input  logic                            s_tuser,   // action: 0 allocate, 1 free

    // result item
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fba_pkg::OUT_TDATA_W-1:0] m_tdata    // entry_base[19:0], present_bit[20],
                                                       // write_bit[21], user_bit[22],
                                                       // status[24:23], zero pad
);

    fba_pkg::cmd_t cmd;
    fba_pkg::sts_t sts;

    // Controller: owns the handshakes and sequencing. The result register
    // sits in the datapath, so a new request is taken while the previous
    // result still waits for m_tready.
    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: bitmap memory (one word per 32 frames), scan counters,
    // lowest-zero-bit encoder, request and result registers.
    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

>>> bench/frame_bitmap_allocator_tb.sv
// Self-checking bench for frame_bitmap_allocator: first-fit frame allocation and freeing.
// Keeps its own bitmap predictor; depends on fba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module frame_bitmap_allocator_tb;

    localparam int FRAME_W      = fba_pkg::FRAME_W;
    localparam int FC_W         = fba_pkg::FC_W;
    localparam int MAX_FRAMES   = 4096;
    // bitmap storage is whole 32-frame words
    localparam int STORE_FRAMES = ((MAX_FRAMES + 31) / 32) * 32;
    // worst allocate: a full scan of every word plus overhead
    localparam int SCAN_LATENCY = MAX_FRAMES / 32 + 8;
    // worst run is roughly 1700 items x (scan + stalls); this is several times that
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int BLOCK_ITEMS  = 95;

    // result item layout, MSB first, so that a cast from m_tdata[24:0] lines up
    typedef struct packed {
        logic [1:0]         status;
        logic               user;
        logic               writable;
        logic               present;
        logic [FRAME_W-1:0] entry_base;
    } frame_result_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wen   = 1'b0;
    logic [FC_W-1:0]                 cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [fba_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;   // page_base[19:0], kernel_page[20],
                                                       // writable[21], zero pad
    logic                            s_tuser   = 1'b0; // action
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [fba_pkg::OUT_TDATA_W-1:0] m_tdata;          // entry_base[19:0], present[20],
                                                       // write[21], user[22],
                                                       // status[24:23], zero pad

    // predictor state
    logic            frame_used [STORE_FRAMES];
    logic [FC_W-1:0] managed_frames;
    int              held_frames [$];        // frames handed out, candidates for freeing
    frame_result_t   expected_results [$];

    int     error_count   = 0;
    int     src_idle_pct  = 0;
    int     sink_idle_pct = 0;
    longint cycle_count   = 0;

    frame_bitmap_allocator #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // First-fit allocation over whole words below min(frame_count, MAX_FRAMES); frees clear the bit.
    function automatic frame_result_t predict_request(logic act, logic [FRAME_W-1:0] page_base,
                                                      logic kernel, logic writeable);
        frame_result_t res;
        int            limit;
        int            found;
        int            f;
        res            = '0;
        res.entry_base = page_base;
        if (act == fba_pkg::ACT_ALLOC)
        begin
            if (page_base != 0)
            begin
                res.status = fba_pkg::ST_IDLE;   // page already backed
            end
            else
            begin
                limit = (managed_frames > MAX_FRAMES) ? MAX_FRAMES : int'(managed_frames);
                limit = (limit / 32) * 32;
                found = -1;
                for (f = 0; f < limit && found < 0; f++)
                begin
                    if (!frame_used[f])
                        found = f;
                end
                if (found < 0)
                begin
                    res.status = fba_pkg::ST_FULL;
                end
                else
                begin
                    frame_used[found] = 1'b1;
                    held_frames.push_back(found);
                    res.entry_base = found[FRAME_W-1:0];
                    res.present    = 1'b1;
                    res.writable   = writeable;
                    res.user       = ~kernel;
                    res.status     = fba_pkg::ST_DONE;
                end
            end
        end
        else
        begin
            if (page_base == 0)
            begin
                res.status = fba_pkg::ST_IDLE;
            end
            else
            begin
                // frames past storage leave the bitmap alone but still report done
                if (page_base < STORE_FRAMES)
                    frame_used[page_base] = 1'b0;
                res.entry_base = '0;
                res.status     = fba_pkg::ST_DONE;
            end
        end
        return res;
    endfunction

    // One request item; valid stays high across back-to-back items.
    task automatic send_request(input logic act, input logic [FRAME_W-1:0] page_base,
                                input logic kernel, input logic writeable);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, writeable, kernel, page_base};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_request(act, page_base, kernel, writeable));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write only once the block has gone quiet.
    task automatic write_frame_count(input logic [FC_W-1:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wen        <= 1'b1;
        cfg_wdata      <= value;
        managed_frames  = value;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Result check against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        frame_result_t got;
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = frame_result_t'(m_tdata[24:0]);
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: base=%h status=%0d", got.entry_base,
                             got.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.entry_base !== want.entry_base || got.present !== want.present ||
                    got.writable !== want.writable || got.user !== want.user ||
                    got.status !== want.status)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: base %h/%h present %b/%b write %b/%b ",
                                  "user %b/%b status %0d/%0d (exp/act)"},
                                 want.entry_base, got.entry_base, want.present, got.present,
                                 want.writable, got.writable, want.user, got.user,
                                 want.status, got.status);
                end
            end
        end
    end

    // Plain requests at the reset frame_count: frame 0 handed out, no-op cases,
    // frees past storage, and a freed frame coming back first.
    task automatic test_directed_requests();
        send_request(fba_pkg::ACT_ALLOC, 20'h0,     1'b0, 1'b0);   // gets frame 0
        send_request(fba_pkg::ACT_ALLOC, 20'h0,     1'b1, 1'b1);   // frame 1, kernel, writable
        send_request(fba_pkg::ACT_ALLOC, 20'hFFFFF, 1'b1, 1'b1);   // already backed
        send_request(fba_pkg::ACT_FREE,  20'h0,     1'b0, 1'b0);   // nothing held
        send_request(fba_pkg::ACT_FREE,  20'hFFFFF, 1'b1, 1'b1);   // far past storage
        // first frame past storage
        send_request(fba_pkg::ACT_FREE,  STORE_FRAMES[FRAME_W-1:0], 1'b0, 1'b1);
        send_request(fba_pkg::ACT_FREE,  20'h1,     1'b0, 1'b0);
        send_request(fba_pkg::ACT_ALLOC, 20'h0,     1'b0, 1'b1);   // frame 1 again
        send_request(fba_pkg::ACT_FREE,  STORE_FRAMES[FRAME_W-1:0] - 20'h1, 1'b1, 1'b0);
    endtask

    // Register extremes: nothing searched, under one word, one word, above MAX_FRAMES.
    task automatic test_frame_count_extremes();
        write_frame_count(13'd0);
        send_request(fba_pkg::ACT_ALLOC, 20'h0, 1'b0, 1'b1);       // no free frame
        write_frame_count(13'd31);
        send_request(fba_pkg::ACT_ALLOC, 20'h0, 1'b1, 1'b0);       // partial word never searched
        write_frame_count(13'd32);
        send_request(fba_pkg::ACT_ALLOC, 20'h0, 1'b0, 1'b1);
        send_request(fba_pkg::ACT_FREE,  20'd100, 1'b0, 1'b0);     // above frame_count, stored
        write_frame_count(13'h1FFF);
        send_request(fba_pkg::ACT_ALLOC, 20'h0, 1'b1, 1'b1);
        send_request(fba_pkg::ACT_FREE,  20'h2, 1'b0, 1'b0);
    endtask

    function automatic logic [FC_W-1:0] pick_frame_count();
        unique case ($urandom_range(9))
            0, 1, 2, 3, 4: return FC_W'($urandom_range(32, 160));   // small: fills up often
            5:             return fba_pkg::FC_RESET;
            6:             return 13'h1FFF;
            7:             return FC_W'($urandom_range(0, 8191));
            8:             return FC_W'($urandom_range(161, 600));
            default:       return FC_W'($urandom_range(0, 31));
        endcase
    endfunction

    // Mostly allocate/free pairs on live frames, plus no-op and stray frees.
    task automatic send_random_request();
        int pick;
        int idx;
        int frame;
        pick = $urandom_range(99);
        if (pick < 45 || (pick < 80 && held_frames.size() == 0))
        begin
            send_request(fba_pkg::ACT_ALLOC, 20'h0, 1'($urandom), 1'($urandom));
        end
        else if (pick < 80)
        begin
            idx   = $urandom_range(0, held_frames.size() - 1);
            frame = held_frames[idx];
            held_frames.delete(idx);
            send_request(fba_pkg::ACT_FREE, frame[FRAME_W-1:0], 1'($urandom), 1'($urandom));
        end
        else if (pick < 88)
        begin
            send_request(fba_pkg::ACT_ALLOC, FRAME_W'($urandom_range(1, 20'hFFFFF)),
                         1'($urandom), 1'($urandom));
        end
        else if (pick < 92)
        begin
            send_request(fba_pkg::ACT_FREE, 20'h0, 1'($urandom), 1'($urandom));
        end
        else if (pick < 97)
        begin
            send_request(fba_pkg::ACT_FREE, FRAME_W'($urandom_range(1, STORE_FRAMES - 1)),
                         1'($urandom), 1'($urandom));
        end
        else
        begin
            send_request(fba_pkg::ACT_FREE, FRAME_W'($urandom_range(1, 20'hFFFFF)),
                         1'($urandom), 1'($urandom));
        end
    endtask

    // Blocks of random traffic, each under a freshly written frame_count.
    // Each register write waits for all results, so the sender pauses there.
    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
        int sent;
        int i;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items)
        begin
            write_frame_count(pick_frame_count());
            for (i = 0; i < BLOCK_ITEMS && sent < n_items; i++)
            begin
                send_random_request();
                sent++;
            end
        end
    endtask

    initial
    begin : main_sequence
        int f;
        for (f = 0; f < STORE_FRAMES; f++)
            frame_used[f] = 1'b0;
        managed_frames = fba_pkg::FC_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_frame_count_extremes();
        test_random_traffic(570, 31, 72);
        test_random_traffic(570, 72, 31);
        test_random_traffic(570, 0, 0);

        drain_results();
        repeat (SCAN_LATENCY) @(posedge clk);
        if (expected_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/fba_pkg.sv
hdl/fba_datapath.sv
hdl/fba_ctrl.sv
hdl/frame_bitmap_allocator.sv
bench/frame_bitmap_allocator_tb.sv
